// ===== src/rpw_pkg.sv =====
// Shared types, widths and register indexes for the range pixel back-projection block.
// Used by every module under src; depends on nothing.
package rpw_pkg;

  localparam int INDEX_BITS = 11;
  localparam int RANGE_BITS = 24;

  localparam int DW   = ((INDEX_BITS + 5 > 17) ? INDEX_BITS + 5 : 17) + 1;
  localparam int D2W  = 2 * DW;
  localparam int SQW  = D2W + 16;
  localparam int SRW  = SQW / 2;
  localparam int NMW  = RANGE_BITS + DW + 7;
  localparam int XW   = NMW + 1;
  localparam int QW   = RANGE_BITS + 2;
  localparam int CW   = QW + 1;
  localparam int PW   = CW + 16;
  localparam int AW   = PW + 2;
  localparam int OW   = 24;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 48;

  localparam int SAT_MAX = 8388607;
  localparam int SAT_MIN = -8388608;

  localparam logic [CFG_IW-1:0] CFG_FOCAL = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CCOL  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_CROW  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ROTX  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ROTY  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_ROTZ  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_TRANS = 3'd6;

  typedef struct packed {
    logic [INDEX_BITS-1:0] pixel_row;
    logic [INDEX_BITS-1:0] pixel_col;
    logic [RANGE_BITS-1:0] ray_range;
    logic                  range_valid;
  } pixel_t;

  typedef struct packed {
    logic signed [OW-1:0] world_x;
    logic signed [OW-1:0] world_y;
    logic signed [OW-1:0] world_z;
    logic                 overflow;
  } point_t;

  typedef struct packed {
    logic [15:0] focal_length;
    logic [15:0] center_col;
    logic [15:0] center_row;
  } cam_cfg_t;

  typedef struct packed {
    logic [CFG_DW-1:0] rot_x;
    logic [CFG_DW-1:0] rot_y;
    logic [CFG_DW-1:0] rot_z;
    logic [CFG_DW-1:0] trans;
  } pose_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] rng;
    logic [2:0][DW-1:0]    d;
  } ray_t;

endpackage

// ===== src/rpw_ray.sv =====
// Ray vector and squared length stages: offsets from the principal point, squares, sum.
// Depends on rpw_pkg.
module rpw_ray import rpw_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  pixel_t         pix,
  input  cam_cfg_t       cam_cfg,
  output logic           out_v,
  output logic [D2W-1:0] out_d2,
  output ray_t           out_ray
);

  logic v1_r, v2_r, v3_r;
  ray_t ray1_r, ray2_r, ray3_r, ray1_nxt;
  logic [2:0][D2W-1:0] sq2_r, sq2_nxt;
  logic [D2W-1:0] d2_r, d2_nxt;
  logic [DW-1:0] colx, rowx;
  logic signed [D2W-1:0] sq_s [3];

  always_comb begin
    colx = DW'(pix.pixel_col) << 4;
    rowx = DW'(pix.pixel_row) << 4;
    ray1_nxt.rng  = pix.ray_range;
    ray1_nxt.d[0] = colx - DW'(cam_cfg.center_col);
    ray1_nxt.d[1] = rowx - DW'(cam_cfg.center_row);
    ray1_nxt.d[2] = DW'(cam_cfg.focal_length);
    for (int k = 0; k < 3; k++) begin
      sq_s[k] = $signed(ray1_r.d[k]) * $signed(ray1_r.d[k]);
      sq2_nxt[k] = D2W'(unsigned'(sq_s[k]));
    end
    d2_nxt = sq2_r[0] + sq2_r[1] + sq2_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v & pix.range_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r <= ray1_nxt;
      ray2_r <= ray1_r;
      sq2_r  <= sq2_nxt;
      ray3_r <= ray2_r;
      d2_r   <= d2_nxt;
    end
  end

  assign out_v   = v3_r;
  assign out_d2  = d2_r;
  assign out_ray = ray3_r;

endmodule

// ===== src/rpw_sqrt.sv =====
// Pipelined integer square root of the scaled squared ray length, one root bit per stage.
// Depends on rpw_pkg.
module rpw_sqrt import rpw_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [D2W-1:0] in_d2,
  input  ray_t           in_ray,
  output logic           out_v,
  output logic [SRW-1:0] out_root,
  output ray_t           out_ray
);

  logic           v_r    [SRW];
  logic [SRW:0]   rem_r  [SRW];
  logic [SRW-1:0] root_r [SRW];
  logic [SQW-1:0] x_r    [SRW];
  ray_t           ray_r  [SRW];

  for (genvar j = 0; j < SRW; j++) begin : g_st
    logic           v_in;
    logic [SRW:0]   rem_in;
    logic [SRW-1:0] root_in;
    logic [SQW-1:0] x_in;
    ray_t           ray_in;
    logic [SRW+2:0] rem_sh, trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = {in_d2, 16'b0};
      assign ray_in  = in_ray;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign x_in    = x_r[j-1];
      assign ray_in  = ray_r[j-1];
    end

    always_comb begin
      rem_sh = {rem_in, x_in[SQW-1 -: 2]};
      trial  = (SRW+3)'({root_in, 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? (SRW+1)'(rem_sh - trial) : (SRW+1)'(rem_sh);
        root_r[j] <= {root_in[SRW-2:0], ge};
        x_r[j]    <= x_in << 2;
        ray_r[j]  <= ray_in;
      end
    end
  end

  assign out_v    = v_r[SRW-1];
  assign out_root = root_r[SRW-1];
  assign out_ray  = ray_r[SRW-1];

endmodule

// ===== src/rpw_div.sv =====
// Camera-space point: range times ray component over ray length, rounded, by three
// pipelined restoring dividers with one quotient bit per stage. Depends on rpw_pkg.
module rpw_div import rpw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [SRW-1:0]    in_root,
  input  ray_t              in_ray,
  output logic              out_v,
  output logic [2:0][CW-1:0] out_cam
);

  logic           vp_r, nzp_r;
  logic [SRW-1:0] np_r;
  logic [SRW-1:0] remp_r [3];
  logic [QW-1:0]  xlp_r  [3];
  logic           negp_r [3];
  logic [SRW-1:0] remp_nxt [3];
  logic [QW-1:0]  xlp_nxt  [3];
  logic           negp_nxt [3];
  logic [DW-1:0]  dabs [3];
  logic [NMW-1:0] mag [3];
  logic [XW-1:0]  xw [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      negp_nxt[k] = in_ray.d[k][DW-1];
      dabs[k] = negp_nxt[k] ? DW'(-in_ray.d[k]) : in_ray.d[k];
      mag[k]  = (NMW'(in_ray.rng) * NMW'(dabs[k])) << 8;
      xw[k]   = XW'(mag[k]) + XW'(in_root >> 1);
      remp_nxt[k] = SRW'(xw[k] >> QW);
      xlp_nxt[k]  = xw[k][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np_r  <= in_root;
      nzp_r <= in_root != '0;
      for (int k = 0; k < 3; k++) begin
        remp_r[k] <= remp_nxt[k];
        xlp_r[k]  <= xlp_nxt[k];
        negp_r[k] <= negp_nxt[k];
      end
    end
  end

  logic           v_r   [QW];
  logic           nz_r  [QW];
  logic [SRW-1:0] n_r   [QW];
  logic [SRW-1:0] rem_r [QW][3];
  logic [QW-1:0]  xl_r  [QW][3];
  logic [QW-1:0]  q_r   [QW][3];
  logic           neg_r [QW][3];

  for (genvar j = 0; j < QW; j++) begin : g_st
    logic           v_in, nz_in;
    logic [SRW-1:0] n_in;
    logic [SRW-1:0] rem_in [3];
    logic [QW-1:0]  xl_in  [3];
    logic [QW-1:0]  q_in   [3];
    logic           neg_in [3];
    logic [SRW:0]   rem_sh [3];
    logic           ge     [3];

    if (j == 0) begin : g_first
      assign v_in  = vp_r;
      assign nz_in = nzp_r;
      assign n_in  = np_r;
      for (genvar k = 0; k < 3; k++) begin : g_ln
        assign rem_in[k] = remp_r[k];
        assign xl_in[k]  = xlp_r[k];
        assign q_in[k]   = '0;
        assign neg_in[k] = negp_r[k];
      end
    end else begin : g_next
      assign v_in  = v_r[j-1];
      assign nz_in = nz_r[j-1];
      assign n_in  = n_r[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_ln
        assign rem_in[k] = rem_r[j-1][k];
        assign xl_in[k]  = xl_r[j-1][k];
        assign q_in[k]   = q_r[j-1][k];
        assign neg_in[k] = neg_r[j-1][k];
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem_sh[k] = {rem_in[k], xl_in[k][QW-1]};
        ge[k]     = rem_sh[k] >= {1'b0, n_in};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nz_r[j] <= nz_in;
        n_r[j]  <= n_in;
        for (int k = 0; k < 3; k++) begin
          rem_r[j][k] <= ge[k] ? SRW'(rem_sh[k] - {1'b0, n_in}) : SRW'(rem_sh[k]);
          xl_r[j][k]  <= xl_in[k] << 1;
          q_r[j][k]   <= {q_in[k][QW-2:0], ge[k]};
          neg_r[j][k] <= neg_in[k];
        end
      end
    end
  end

  logic v_out_r;
  logic [2:0][CW-1:0] cam_r, cam_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!nz_r[QW-1]) begin
        cam_nxt[k] = '0;
      end else if (neg_r[QW-1][k]) begin
        cam_nxt[k] = -CW'(q_r[QW-1][k]);
      end else begin
        cam_nxt[k] = CW'(q_r[QW-1][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else if (en) begin
      v_out_r <= v_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cam_r <= cam_nxt;
    end
  end

  assign out_v   = v_out_r;
  assign out_cam = cam_r;

endmodule

// ===== src/rpw_xform.sv =====
// Rigid transform to world space: nine products, then sum, rounding and saturation.
// Depends on rpw_pkg.
module rpw_xform import rpw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [2:0][CW-1:0] in_cam,
  input  pose_t              pose,
  output logic               out_v,
  output point_t             out_pt
);

  logic va_r, vb_r;
  logic signed [PW-1:0] p_r   [3][3];
  logic signed [PW-1:0] p_nxt [3][3];
  logic [CFG_DW-1:0] rows [3];
  point_t pt_r, pt_nxt;
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] rnd [3];
  logic signed [OW-1:0] w   [3];
  logic                 ovf [3];
  logic signed [15:0]   t   [3];

  always_comb begin
    rows[0] = pose.rot_x;
    rows[1] = pose.rot_y;
    rows[2] = pose.rot_z;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        p_nxt[i][k] = $signed(rows[i][16*k +: 16]) * $signed(in_cam[k]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]   = $signed(pose.trans[16*i +: 16]);
      acc[i] = AW'(p_r[i][0]) + AW'(p_r[i][1]) + AW'(p_r[i][2]) + (AW'(t[i]) <<< 18);
      rnd[i] = (acc[i] + AW'(8192)) >>> 14;
      if (rnd[i] > AW'(SAT_MAX)) begin
        w[i] = OW'(SAT_MAX);
        ovf[i] = 1'b1;
      end else if (rnd[i] < AW'(SAT_MIN)) begin
        w[i] = OW'(SAT_MIN);
        ovf[i] = 1'b1;
      end else begin
        w[i] = OW'(rnd[i]);
        ovf[i] = 1'b0;
      end
    end
    pt_nxt.world_x  = w[0];
    pt_nxt.world_y  = w[1];
    pt_nxt.world_z  = w[2];
    pt_nxt.overflow = ovf[0] | ovf[1] | ovf[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_v;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= p_nxt;
      pt_r <= pt_nxt;
    end
  end

  assign out_v  = vb_r;
  assign out_pt = pt_r;

endmodule

// ===== src/range_pixel_to_world_point.sv =====
// Top level of the range pixel back-projection block: configuration registers and the
// pipeline of ray, square root, divider and transform stages. Depends on rpw_pkg.
//
// Pixels enter on in_valid/in_data; a transfer happens when in_valid is high and
// in_stall is low. Each transferred pixel with range_valid set passes through 3 ray stages,
// 26 square-root stages, 28 divider stages and 2 transform stages and leaves as one
// world point on out_valid/out_data; a pixel with range_valid clear takes its slot in
// the pipeline and gives no transfer.
// One pixel is taken every cycle while in_stall is low; that rate is set by the pipelined
// square root and dividers, which produce one bit per stage.
// When the receiver holds out_stall while a point is waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the registers with their defaults:
// focal length 1000 pixels, center (800, 600), identity rotation, zero translation.
// The user must write registers through cfg_we/cfg_index/cfg_wdata only while the
// pipeline is empty; the block itself does not enforce this.
module range_pixel_to_world_point import rpw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pixel_t            in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output point_t            out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic [15:0] focal_r, ccol_r, crow_r;
  logic [CFG_DW-1:0] rotx_r, roty_r, rotz_r, trans_r;
  cam_cfg_t cam_cfg;
  pose_t pose;
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= 16'd16000;
      ccol_r  <= 16'd12800;
      crow_r  <= 16'd9600;
      rotx_r  <= CFG_DW'(16384);
      roty_r  <= CFG_DW'(16384) << 16;
      rotz_r  <= CFG_DW'(16384) << 32;
      trans_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL: focal_r <= cfg_wdata[15:0];
        CFG_CCOL:  ccol_r  <= cfg_wdata[15:0];
        CFG_CROW:  crow_r  <= cfg_wdata[15:0];
        CFG_ROTX:  rotx_r  <= cfg_wdata;
        CFG_ROTY:  roty_r  <= cfg_wdata;
        CFG_ROTZ:  rotz_r  <= cfg_wdata;
        CFG_TRANS: trans_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cam_cfg.focal_length = focal_r;
    cam_cfg.center_col   = ccol_r;
    cam_cfg.center_row   = crow_r;
    pose.rot_x = rotx_r;
    pose.rot_y = roty_r;
    pose.rot_z = rotz_r;
    pose.trans = trans_r;
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic           ray_v, sq_v, div_v;
  logic [D2W-1:0] ray_d2;
  ray_t           ray_d, sq_ray;
  logic [SRW-1:0] sq_root;
  logic [2:0][CW-1:0] div_cam;

  rpw_ray u_ray (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(in_valid), .pix(in_data), .cam_cfg(cam_cfg),
    .out_v(ray_v), .out_d2(ray_d2), .out_ray(ray_d)
  );

  rpw_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(ray_v), .in_d2(ray_d2), .in_ray(ray_d),
    .out_v(sq_v), .out_root(sq_root), .out_ray(sq_ray)
  );

  rpw_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(sq_v), .in_root(sq_root), .in_ray(sq_ray),
    .out_v(div_v), .out_cam(div_cam)
  );

  rpw_xform u_xform (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(div_v), .in_cam(div_cam), .pose(pose),
    .out_v(out_valid), .out_pt(out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      out_data.world_x == OW'(SAT_MAX) || out_data.world_x == OW'(SAT_MIN) ||
      out_data.world_y == OW'(SAT_MAX) || out_data.world_y == OW'(SAT_MIN) ||
      out_data.world_z == OW'(SAT_MAX) || out_data.world_z == OW'(SAT_MIN))
    else $error("overflow flagged without a saturated coordinate");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule
